### design/horner_poly_eval_real_macros.svh
// assertion macros for the horner polynomial evaluator
`ifndef HORNER_POLY_EVAL_REAL_MACROS_SVH
`define HORNER_POLY_EVAL_REAL_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HPE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("horner evaluator check failed");

// antecedent implies consequent in the next cycle
`define HPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("horner evaluator check failed");

`endif

### design/hpe_pkg.sv
// types and constants shared by the horner polynomial evaluator
package hpe_pkg;

  localparam int MAX_TERMS = 7;
  localparam int REG_COUNT = 7;
  localparam int NUM_STEPS = MAX_TERMS - 1;
  localparam int LATENCY   = 1 + 2 * NUM_STEPS;
  localparam int TC_W      = 3;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_TERM_COUNT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COEF_BASE  = IDX_W'(1);

  localparam logic [TC_W-1:0] TERM_COUNT_RESET = TC_W'(1);

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [48:0] sum_t;

  typedef struct packed {
    word_t sample_in;
    logic  block_end_in;
  } in_t;

  typedef struct packed {
    word_t value_out;
    logic  block_end_out;
  } out_t;

  typedef struct packed {
    logic [TC_W-1:0]            term_count;
    word_t [REG_COUNT-1:0]      coef;
  } cfg_t;

  typedef struct packed {
    word_t y;
    word_t x;
    logic  block_end;
  } pipe_t;

  function automatic word_t sat32(input sum_t v);
    word_t r;
    r = v[31:0];
    if (v[48:31] != {18{v[48]}}) begin
      r = v[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

### design/hpe_regs.sv
// apb register file holding term count and coefficients
module hpe_regs import hpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [IDX_W-1:0] idx;
  logic             wr;
  logic [IDX_W-1:0] cidx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign cidx   = idx - REG_COEF_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.term_count <= TERM_COUNT_RESET;
      cfg.coef       <= '0;
    end else if (wr) begin
      if (idx == REG_TERM_COUNT) begin
        cfg.term_count <= pwdata[TC_W-1:0];
      end else begin
        cfg.coef[cidx] <= pwdata;
      end
    end
  end

  always_comb begin
    if (idx == REG_TERM_COUNT) begin
      prdata = {{(32-TC_W){1'b0}}, cfg.term_count};
    end else begin
      prdata = cfg.coef[cidx];
    end
  end

endmodule

### design/hpe_step.sv
// one horner step: registered multiply, then shift, add and saturate
module hpe_step import hpe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid_in,
  input  pipe_t pipe_in,
  input  word_t coef,
  input  logic  active,
  output logic  valid_out,
  output pipe_t pipe_out
);

  logic  mul_valid;
  prod_t mul_prod;
  pipe_t mul_pipe;
  sum_t  sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    mul_prod <= prod_t'(pipe_in.y) * prod_t'(pipe_in.x);
    mul_pipe <= pipe_in;
  end

  assign sum = sum_t'(signed'(mul_prod[63:16])) + sum_t'(coef);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    pipe_out.x         <= mul_pipe.x;
    pipe_out.block_end <= mul_pipe.block_end;
    pipe_out.y         <= active ? sat32(sum) : mul_pipe.y;
  end

endmodule

### design/horner_poly_eval_real.sv
// horner polynomial evaluator top level: one sample per cycle through one input
// register plus a multiply stage and an add/saturate stage per horner step; busy is
// high only during reset, and each result appears on result for a single cycle with
// done high, so the receiver must take it then
module horner_poly_eval_real import hpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_t               request,
  output logic              done,
  output out_t              result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "horner_poly_eval_real_macros.svh"

  cfg_t  cfg;
  logic  accept;
  logic  in_valid;
  pipe_t in_pipe;
  logic  stage_valid [NUM_STEPS+1];
  pipe_t stage_pipe  [NUM_STEPS+1];

  hpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_pipe.y         <= cfg.coef[0];
    in_pipe.x         <= request.sample_in;
    in_pipe.block_end <= request.block_end_in;
  end

  assign stage_valid[0] = in_valid;
  assign stage_pipe[0]  = in_pipe;

  for (genvar j = 1; j <= NUM_STEPS; j++) begin : g_step
    hpe_step u_step (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (stage_valid[j-1]),
      .pipe_in   (stage_pipe[j-1]),
      .coef      (cfg.coef[j]),
      .active    (TC_W'(j) < cfg.term_count),
      .valid_out (stage_valid[j]),
      .pipe_out  (stage_pipe[j])
    );
  end

  assign done                 = stage_valid[NUM_STEPS];
  assign result.value_out     = stage_pipe[NUM_STEPS].y;
  assign result.block_end_out = stage_pipe[NUM_STEPS].block_end;

  `HPE_ASSERT_NEXT(a_enter, accept, stage_valid[0])
  `HPE_ASSERT_IMPL(a_latency, done, $past(accept, LATENCY))
  `HPE_ASSERT_IMPL(a_block_end, done,
    result.block_end_out == $past(request.block_end_in, LATENCY))

endmodule

### tb/tb_horner_poly_eval_real.sv
// testbench for the horner polynomial evaluator: directed and random samples against a predictor
module tb_horner_poly_eval_real;
  import hpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint WORD_MAX = longint'(32'sh7fff_ffff);
  localparam longint WORD_MIN = longint'(32'sh8000_0000);

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  in_t               request = '0;
  logic              done;
  out_t              result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic [TC_W-1:0] term_count_q = TERM_COUNT_RESET;
  word_t           coef_q [REG_COUNT];
  out_t            pending_values [$];
  out_t            want_value;
  int              error_count = 0;
  int              idle_cycles = 0;

  horner_poly_eval_real DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (coef_q[i]) coef_q[i] = '0;
  end

  function automatic word_t eval_poly(input word_t x);
    longint acc;
    longint prod;
    int     n;
    n = (term_count_q == 0) ? 1 : int'(term_count_q);
    if (n > MAX_TERMS) n = MAX_TERMS;
    acc = longint'(coef_q[0]);
    for (int j = 1; j < n; j++) begin
      prod = acc * longint'(x);
      acc = (prod >>> 16) + longint'(coef_q[j]);
      if (acc > WORD_MAX) acc = WORD_MAX;
      if (acc < WORD_MIN) acc = WORD_MIN;
    end
    return word_t'(acc[31:0]);
  endfunction

  function automatic word_t rand_word();
    word_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = word_t'($urandom);
      4, 5, 6, 7: v = word_t'($urandom_range(0, 'h80000)) - word_t'('h40000);
      8: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7fff_ffff;
          1: v = 32'sh8000_0000;
          2: v = 32'sh0000_0000;
          3: v = 32'shffff_ffff;
          default: v = 32'sh0000_0001;
        endcase
      end
      default: v = word_t'($urandom_range(0, 'h2000)) + word_t'('h10000 - 'h1000);
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request handshake; start is left high so back-to-back requests need no toggle
  task automatic send_sample(input word_t x, input logic be);
    out_t exp_v;
    start <= 1'b1;
    request <= '{sample_in: x, block_end_in: be};
    do @(posedge clk); while (busy);
    exp_v.value_out = eval_poly(x);
    exp_v.block_end_out = be;
    pending_values.push_back(exp_v);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) begin
        request <= '{sample_in: word_t'($urandom), block_end_in: 1'($urandom_range(0, 1))};
        @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_TERM_COUNT) term_count_q = data[TC_W-1:0];
    else coef_q[idx - REG_COEF_BASE] = word_t'(data);
  endtask

  task automatic load_config(input logic [TC_W-1:0] n, input word_t c [REG_COUNT]);
    drain_results();
    cfg_write(REG_TERM_COUNT, 32'(n));
    for (int j = 0; j < REG_COUNT; j++) cfg_write(REG_COEF_BASE + IDX_W'(j), c[j]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_sample(32'sh7fff_ffff, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
  endtask

  task automatic test_extremes();
    word_t c [REG_COUNT];
    foreach (c[j]) c[j] = 32'sh7fff_ffff;
    load_config(3'd7, c);
    send_sample(32'sh7fff_ffff, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0000_0000, 1'b1);
    send_sample(32'sh0001_0000, 1'b0);
    foreach (c[j]) c[j] = 32'sh8000_0000;
    load_config(3'd7, c);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'shffff_ffff, 1'b0);
  endtask

  // arithmetic shift rounds toward minus infinity
  task automatic test_floor_shift();
    word_t c [REG_COUNT];
    foreach (c[j]) c[j] = word_t'($urandom);
    c[0] = 32'shffff_ffff;
    c[1] = 32'sh0000_0000;
    load_config(3'd2, c);
    send_sample(32'sh0000_0001, 1'b0);
    send_sample(32'sh0001_0000, 1'b1);
    send_sample(32'shffff_ffff, 1'b0);
  endtask

  task automatic test_zero_terms();
    word_t c [REG_COUNT];
    foreach (c[j]) c[j] = word_t'($urandom);
    c[0] = 32'sh1234_5678;
    load_config(3'd0, c);
    send_sample(word_t'($urandom), 1'b1);
    send_sample(32'sh7fff_ffff, 1'b0);
  endtask

  // a clipped partial sum must feed the next step
  task automatic test_clipped_partial();
    word_t c [REG_COUNT];
    foreach (c[j]) c[j] = '0;
    c[0] = 32'sh7fff_ffff;
    c[1] = 32'sh7fff_ffff;
    c[2] = 32'sh8000_0000;
    load_config(3'd3, c);
    send_sample(32'sh0002_0000, 1'b0);
    send_sample(32'shfffe_0000, 1'b1);
  endtask

  task automatic test_term_counts();
    word_t c [REG_COUNT];
    for (int n = 0; n <= 7; n++) begin
      foreach (c[j]) c[j] = rand_word();
      load_config(TC_W'(n), c);
      repeat (6) begin
        send_sample(rand_word(), 1'($urandom_range(0, 1)));
        idle_gap(pick_gap());
      end
    end
  endtask

  task automatic test_random_stream();
    word_t c [REG_COUNT];
    logic  burst;
    for (int p = 0; p < 20; p++) begin
      foreach (c[j]) c[j] = rand_word();
      load_config(TC_W'($urandom_range(0, 7)), c);
      burst = ($urandom_range(0, 3) == 0);
      repeat (80) begin
        send_sample(rand_word(), 1'($urandom_range(0, 1)));
        if (!burst) idle_gap(pick_gap());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_values.size() == 0) begin
        $display("%0t unexpected result: expected none, actual value %h end %b",
                 $time, result.value_out, result.block_end_out);
        error_count++;
      end else begin
        want_value = pending_values.pop_front();
        if (result.value_out !== want_value.value_out) begin
          $display("%0t value mismatch: expected %h, actual %h",
                   $time, want_value.value_out, result.value_out);
          error_count++;
        end
        if (result.block_end_out !== want_value.block_end_out) begin
          $display("%0t block end mismatch: expected %b, actual %b",
                   $time, want_value.block_end_out, result.block_end_out);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (psel && penable && pwrite && pready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_extremes();
    test_floor_shift();
    test_zero_terms();
    test_clipped_partial();
    test_term_counts();
    test_random_stream();
    drain_results();
    repeat (5) @(posedge clk);
    if (error_count == 0 && pending_values.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
